>>> sv/tbpc_pkg.sv
// Shared types and constants for the two-button press classifier.
// Used by tbpc_classify and two_button_press_classifier; no dependencies.
package tbpc_pkg;

	localparam int TIME_BITS = 32;
	localparam int CFG_BITS  = 16;

	localparam logic [CFG_BITS-1:0] LONG_HOLD_RESET = 16'd1000;
	localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET  = 16'd50;

	// Configuration register indexes
	typedef enum logic {
		REG_LONG_HOLD = 1'b0,
		REG_DEBOUNCE  = 1'b1
	} cfg_reg_t;

	// Result codes
	typedef enum logic [2:0] {
		EV_NONE       = 3'd0,
		EV_SHORT_UP   = 3'd1,
		EV_LONG_UP    = 3'd2,
		EV_SHORT_DOWN = 3'd3,
		EV_LONG_DOWN  = 3'd4,
		EV_BOTH       = 3'd5
	} press_event_t;

	typedef struct packed {
		logic                 up;
		logic                 down;
		logic [TIME_BITS-1:0] now;
	} sample_t;

	typedef struct packed {
		logic                 up_was;
		logic                 down_was;
		logic                 both_latched;
		logic [TIME_BITS-1:0] up_start;
		logic [TIME_BITS-1:0] down_start;
	} btn_state_t;

endpackage

>>> sv/two_button_press_classifier.sv
// Top level of the two-button press classifier: input register, button
// state, configuration registers and result register. Depends on tbpc_pkg, tbpc_classify.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------
//  in      | request in| in_valid / in_stall   | up_pressed, down_pressed, now_ms
//  out     | result out| out_valid / out_stall | press_event
//  cfg     | write only| cfg_write             | cfg_index, cfg_data
//
// One request per clock while out_stall is low; out_valid rises once an accepted request
// has passed the input register and then the result register.
// The classify step between the registers also updates the button state.
// out_stall holds the result register; the input register then holds too,
// and in_stall rises only while it is full and cannot move on.
// arst_n clears valids and button state and restores register defaults.
module two_button_press_classifier (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               up_pressed,
	input  logic                               down_pressed,
	input  logic [tbpc_pkg::TIME_BITS-1:0]     now_ms,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [2:0]                         press_event,
	// configuration
	input  logic                               cfg_write,
	input  logic                               cfg_index,
	input  logic [tbpc_pkg::CFG_BITS-1:0]      cfg_data
);

	tbpc_pkg::sample_t      sample_s1;
	logic                   valid_s1;
	tbpc_pkg::btn_state_t   state_q, state_nxt;
	tbpc_pkg::press_event_t event_nxt, event_s2;
	logic                   valid_s2;
	logic [tbpc_pkg::CFG_BITS-1:0] long_hold_q, debounce_q;
	logic                   advance, in_take;

	// stage 1 moves on when the result register is free or being emptied
	assign advance  = valid_s1 && !(valid_s2 && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_hold_q <= tbpc_pkg::LONG_HOLD_RESET;
			debounce_q  <= tbpc_pkg::DEBOUNCE_RESET;
		end else if (cfg_write) begin
			case (tbpc_pkg::cfg_reg_t'(cfg_index))
				tbpc_pkg::REG_LONG_HOLD: long_hold_q <= cfg_data;
				tbpc_pkg::REG_DEBOUNCE:  debounce_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register: valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take || (valid_s1 && !advance);
		end
	end

	// input register: payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_s1.up   <= up_pressed;
			sample_s1.down <= down_pressed;
			sample_s1.now  <= now_ms;
		end
	end

	tbpc_classify u_classify (
		.sample     (sample_s1),
		.cur        (state_q),
		.long_hold  (long_hold_q),
		.debounce   (debounce_q),
		.nxt        (state_nxt),
		.event_code (event_nxt)
	);

	// button state advances once per request, in order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_s2 <= event_nxt;
		end
	end

	assign out_valid   = valid_s2;
	assign press_event = event_s2;

endmodule

>>> sv/tbpc_classify.sv
// Combinational edge detect, hold-time measure and event pick for one sample.
// Depends on tbpc_pkg.
module tbpc_classify (
	input  tbpc_pkg::sample_t              sample,
	input  tbpc_pkg::btn_state_t           cur,
	input  logic [tbpc_pkg::CFG_BITS-1:0]  long_hold,
	input  logic [tbpc_pkg::CFG_BITS-1:0]  debounce,
	output tbpc_pkg::btn_state_t           nxt,
	output tbpc_pkg::press_event_t         event_code
);

	logic [tbpc_pkg::TIME_BITS-1:0] up_start, down_start;
	logic [tbpc_pkg::TIME_BITS-1:0] up_hold, down_hold;
	logic [tbpc_pkg::TIME_BITS-1:0] long_ext, deb_ext;
	logic both_fire, latched, up_rel, down_rel;

	always_comb begin
		// rising edge captures the press time
		up_start   = (sample.up && !cur.up_was) ? sample.now : cur.up_start;
		down_start = (sample.down && !cur.down_was) ? sample.now : cur.down_start;

		up_hold   = sample.now - up_start;    // wraps modulo 2^TIME_BITS
		down_hold = sample.now - down_start;
		long_ext  = {{(tbpc_pkg::TIME_BITS-tbpc_pkg::CFG_BITS){1'b0}}, long_hold};
		deb_ext   = {{(tbpc_pkg::TIME_BITS-tbpc_pkg::CFG_BITS){1'b0}}, debounce};

		both_fire = cur.up_was && cur.down_was && (!sample.up || !sample.down);
		latched   = cur.both_latched || both_fire;
		up_rel    = !sample.up && cur.up_was && !sample.down && !latched;
		down_rel  = !sample.down && cur.down_was && !sample.up && !latched;

		event_code = tbpc_pkg::EV_NONE;
		if (both_fire) begin
			event_code = tbpc_pkg::EV_BOTH;
		end
		if (up_rel && (up_hold > deb_ext)) begin
			event_code = (up_hold < long_ext) ? tbpc_pkg::EV_SHORT_UP : tbpc_pkg::EV_LONG_UP;
		end
		if (down_rel && (down_hold > deb_ext)) begin
			event_code = (down_hold < long_ext) ? tbpc_pkg::EV_SHORT_DOWN
							    : tbpc_pkg::EV_LONG_DOWN;
		end

		nxt.up_was       = sample.up;
		nxt.down_was     = sample.down;
		nxt.both_latched = latched && (sample.up || sample.down);
		nxt.up_start     = up_start;
		nxt.down_start   = down_start;
	end

endmodule
